// ===== rtl/core/sid_pkg.sv =====
`default_nettype none
package sid_pkg;

  // sizing
  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CMD_W       = 2;
  localparam int ELEM_W      = 32;
  localparam int POS_W       = 6;
  localparam int STAT_W      = 2;
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // command codes
  localparam logic [CMD_W-1:0] CMD_FRONT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BACK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BAD    = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

  // cell operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_HOLD   = 3'd0;
  localparam logic [OP_W-1:0] OP_FRONT  = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_ROTATE = 3'd4;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  // broadcast to every cell in the row
  typedef struct packed {
    logic [OP_W-1:0]  op;
    value_t           val;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/sid_if.sv =====
`default_nettype none
interface sid_cmd_if;
  import sid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [ELEM_W-1:0] item_value;
  logic [POS_W-1:0]         position;

  modport source (output valid, command, item_value, position, input ready);
  modport sink   (input valid, command, item_value, position, output ready);
endinterface

interface sid_res_if;
  import sid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element;
  logic                     last;
  logic                     list_empty;
  logic [STAT_W-1:0]        status;

  modport source (output valid, element, last, list_empty, status, input ready);
  modport sink   (input valid, element, last, list_empty, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sid_cell.sv =====
`default_nettype none
module sid_cell (
  input  wire logic                    clk,
  input  wire logic [sid_pkg::CNT_W-1:0] idx,
  input  wire sid_pkg::ctrl_t          ctrl,
  input  wire sid_pkg::value_t         left_val,
  input  wire sid_pkg::value_t         right_val,
  input  wire sid_pkg::value_t         head_val,
  output sid_pkg::value_t              val
);
  import sid_pkg::*;

  value_t           val_next;
  logic [CNT_W-1:0] tail_idx;

  assign tail_idx = ctrl.cnt - CNT_W'(1);

  always_comb begin
    val_next = val;
    case (ctrl.op)
      OP_FRONT: begin
        val_next = (idx == '0) ? ctrl.val : left_val;
      end
      OP_APPEND: begin
        if (idx == ctrl.cnt) val_next = ctrl.val;
      end
      OP_DELETE: begin
        if (idx >= ctrl.pos) val_next = right_val;
      end
      OP_ROTATE: begin
        // head wraps around to the tail slot
        if (idx == tail_idx) val_next = head_val;
        else if (idx < tail_idx) val_next = right_val;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/sequence_insert_delete_dump.sv =====
// Latency: first result is offered the cycle after a command transfer.
// Flow: a new command is taken only after the last result of the previous
//   dump; a dump gives count results (count after the command), or one for
//   a bad command or an empty list; the cell row rotates one place per result.
// Reset: sync, active high; clears count and control, cell contents are
//   left undefined and only entries below count are ever shown.
`default_nettype none
module sequence_insert_delete_dump (
  input  wire logic clk,
  input  wire logic rst,
  sid_cmd_if.sink   cmd,
  sid_res_if.source res
);
  import sid_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  // control state
  logic              state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  rd_idx;
  logic [STAT_W-1:0] stat;
  logic              single;   // one-result dump: empty list or bad command

  logic              state_next;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  rd_idx_next;
  logic [STAT_W-1:0] stat_next;
  logic              single_next;

  logic   take;       // command transfer
  logic   give;       // result transfer
  logic   is_full;
  logic   pos_ok;
  logic   is_last;
  ctrl_t  ctrl;

  value_t vals [DEPTH];

  // ---------------------------------------------------------------
  // Cell row. Cell 0 is the front of the list. Every op is a shift
  // by at most one place, so each cell only sees its neighbors, the
  // broadcast control word and the head value (for the wrap on dump).
  // ---------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t lv;
    value_t rv;
    if (i == 0) begin : g_first
      assign lv = ctrl.val;
    end else begin : g_mid_l
      assign lv = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign rv = vals[i];
    end else begin : g_mid_r
      assign rv = vals[i+1];
    end
    sid_cell u_cell (
      .clk       (clk),
      .idx       (CNT_W'(i)),
      .ctrl      (ctrl),
      .left_val  (lv),
      .right_val (rv),
      .head_val  (vals[0]),
      .val       (vals[i])
    );
  end

  // ---------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------
  assign cmd.ready = (state == S_IDLE);
  assign take      = cmd.valid && cmd.ready;
  assign give      = res.valid && res.ready;

  assign is_full = (count == CNT_W'(DEPTH));
  assign pos_ok  = (int'(cmd.position) < int'(count));

  // ---------------------------------------------------------------
  // Command decode: pick the row op and the new count / status.
  // During a dump the row rotates left by one on each transfer; after
  // count transfers the list is back in its original order.
  // ---------------------------------------------------------------
  always_comb begin
    ctrl        = '{op: OP_HOLD, val: value_t'(cmd.item_value),
                    pos: CNT_W'(cmd.position), cnt: count};
    count_next  = count;
    stat_next   = stat;
    single_next = single;

    if (take) begin
      stat_next = ST_OK;
      case (cmd.command)
        CMD_FRONT: begin
          if (is_full) begin
            stat_next = ST_FULL;
          end else begin
            ctrl.op    = OP_FRONT;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_BACK: begin
          if (is_full) begin
            stat_next = ST_FULL;
          end else begin
            ctrl.op    = OP_APPEND;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_DELETE: begin
          if (!pos_ok) begin
            stat_next = ST_RANGE;
          end else begin
            ctrl.op    = OP_DELETE;
            count_next = count - CNT_W'(1);
          end
        end
        default: begin
          stat_next = ST_BAD;
        end
      endcase
      single_next = (stat_next == ST_BAD) || (count_next == '0);
    end else if (give && !single) begin
      ctrl.op = OP_ROTATE;
    end
  end

  // ---------------------------------------------------------------
  // Dump sequencing
  // ---------------------------------------------------------------
  assign is_last = single || (rd_idx == count - CNT_W'(1));

  always_comb begin
    state_next  = state;
    rd_idx_next = rd_idx;
    case (state)
      S_IDLE: begin
        rd_idx_next = '0;
        if (take) state_next = S_DUMP;
      end
      S_DUMP: begin
        if (give) begin
          if (is_last) begin
            state_next  = S_IDLE;
            rd_idx_next = '0;
          end else begin
            rd_idx_next = rd_idx + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next  = S_IDLE;
        rd_idx_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rd_idx <= '0;
      stat   <= ST_OK;
      single <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_idx <= rd_idx_next;
      stat   <= stat_next;
      single <= single_next;
    end
  end

  // ---------------------------------------------------------------
  // Result port: the head cell is the current element, straight from
  // registers; nothing moves until the transfer completes.
  // ---------------------------------------------------------------
  assign res.valid      = (state == S_DUMP);
  assign res.element    = single ? '0 : ELEM_W'(vals[0]);
  assign res.last       = is_last;
  assign res.list_empty = (count == '0);
  assign res.status     = stat;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Checks sequence_insert_delete_dump through its command and result channels.
// A class keeps a mirror of the stored sequence. Each command transfer is
// applied to the mirror, and that yields the dump the block should emit. Each
// result transfer is then checked against the oldest beat still due.
module testbench;
  import sid_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RESET_TICKS = 7;
  localparam int LONG_HOLD   = 300;         // receiver hold-off, in cycles
  localparam int DRAIN_TICKS = 20;          // quiet cycles after the last beat
  localparam int TIMEOUT_NS  = 10_000_000;  // watchdog timeout, in ns
  localparam int MAX_REPORTS = 100;

  // One result beat as the block should present it.
  typedef struct {
    logic signed [ELEM_W-1:0] element;
    logic                     last;
    logic                     list_empty;
    logic [STAT_W-1:0]        status;
  } dump_beat_t;

  // Mirror of the stored sequence plus the queue of dump beats still due.
  class sequence_mirror;
    value_t     contents[$];
    dump_beat_t beats_due[$];
    int         mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int occupancy();
      return contents.size();
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function void push_beat(logic signed [ELEM_W-1:0] element, logic last,
                            logic list_empty, logic [STAT_W-1:0] status);
      dump_beat_t beat;
      beat.element    = element;
      beat.last       = last;
      beat.list_empty = list_empty;
      beat.status     = status;
      beats_due.push_back(beat);
    endfunction

    // Apply one accepted command; queue the dump it causes.
    function void note_command(logic [CMD_W-1:0] code, logic signed [ELEM_W-1:0] value,
                               logic [POS_W-1:0] where);
      logic [STAT_W-1:0] outcome;
      value_t            kept;
      outcome = ST_OK;
      kept    = value;  // keeps the low VALUE_WIDTH bits
      if (code == CMD_BAD) begin
        push_beat('0, 1'b1, contents.size() == 0, ST_BAD);
        return;
      end
      if (code == CMD_FRONT || code == CMD_BACK) begin
        if (contents.size() >= DEPTH) begin
          outcome = ST_FULL;
        end else if (code == CMD_FRONT) begin
          contents.push_front(kept);
        end else begin
          contents.push_back(kept);
        end
      end else if (where >= contents.size()) begin
        outcome = ST_RANGE;
      end else begin
        contents.delete(where);
      end
      if (contents.size() == 0) begin
        push_beat('0, 1'b1, 1'b1, outcome);
      end else begin
        foreach (contents[i]) begin
          push_beat(contents[i], i == contents.size() - 1, 1'b0, outcome);
        end
      end
    endfunction

    function void compare_field(string name, logic [ELEM_W-1:0] want,
                                logic [ELEM_W-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
      end
    endfunction

    // Check one accepted result beat against the oldest one due.
    function void check_beat(dump_beat_t got);
      dump_beat_t want;
      if (beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected result: expected none, actual element %0h last %0b empty %0b status %0d",
                   $time, got.element, got.last, got.list_empty, got.status);
        end
        return;
      end
      want = beats_due.pop_front();
      compare_field("element", want.element, got.element);
      compare_field("last", ELEM_W'(want.last), ELEM_W'(got.last));
      compare_field("list_empty", ELEM_W'(want.list_empty), ELEM_W'(got.list_empty));
      compare_field("status", ELEM_W'(want.status), ELEM_W'(got.status));
    endfunction
  endclass

  logic clk;
  logic rst;

  sid_cmd_if cmd_bus ();
  sid_res_if res_bus ();

  sequence_insert_delete_dump u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .res (res_bus)
  );

  sequence_mirror mirror = new();

  // Idle chances in percent, changed per phase by the stimulus process.
  int send_idle_pct;
  int recv_idle_pct;
  // Bumped by the stimulus to ask the receiver for one long hold-off.
  int holds_asked;

  initial begin
    clk = 1'b0;
  end

  always #CLK_HALF clk = ~clk;

  // Command side. Each call starts at a rising edge and returns at the edge
  // where the transfer happens. valid is left high, so back-to-back commands
  // never lower and raise it within one time step.
  task automatic send_command(input logic [CMD_W-1:0] code,
                              input logic signed [ELEM_W-1:0] value,
                              input logic [POS_W-1:0] where);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= code;
    cmd_bus.item_value <= value;
    cmd_bus.position   <= where;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    mirror.note_command(code, value, where);
  endtask

  // Random command with a given mix; the rest are bad commands. Most deletes
  // hit a stored element; the others draw any position.
  task automatic send_random(input int insert_pct, input int delete_pct);
    int                pick;
    int                used;
    logic [CMD_W-1:0]  code;
    logic [POS_W-1:0]  where;
    pick  = $urandom_range(0, 99);
    used  = mirror.occupancy();
    where = POS_W'($urandom_range(0, 63));
    if (pick < insert_pct) begin
      code = $urandom_range(0, 1) ? CMD_BACK : CMD_FRONT;
    end else if (pick < insert_pct + delete_pct) begin
      code = CMD_DELETE;
      if (used > 0 && $urandom_range(0, 4) != 0) begin
        where = POS_W'($urandom_range(0, used - 1));
      end
    end else begin
      code = CMD_BAD;
    end
    send_command(code, $urandom(), where);
  endtask

  // Stop offering and wait until every dump beat has been seen.
  task automatic wait_for_dumps();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (mirror.pending() != 0);
  endtask

  // Result side: check on every transfer, then pick ready for the next edge.
  // A long hold-off is counted down here when the stimulus asks for one.
  initial begin : result_sink
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_bus.valid && res_bus.ready) begin
        mirror.check_beat('{res_bus.element, res_bus.last, res_bus.list_empty,
                            res_bus.status});
      end
      if (holds_taken != holds_asked) begin
        holds_taken = holds_asked;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    bit held;
    held          = 1'b0;
    holds_asked   = 0;
    send_idle_pct = 28;
    recv_idle_pct = 68;
    rst                <= 1'b1;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.command    <= CMD_FRONT;
    cmd_bus.item_value <= '0;
    cmd_bus.position   <= '0;
    res_bus.ready      <= 1'b0;
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty-list corners, value extremes, deletes at the front,
    // the middle and the back, out-of-range deletes, removing the only
    // element, and bad commands on empty and non-empty lists.
    send_command(CMD_BAD, 32'sh0, 6'd0);
    send_command(CMD_DELETE, 32'sh0, 6'd0);
    send_command(CMD_DELETE, -32'sh1, 6'd63);
    send_command(CMD_FRONT, 32'sh7fffffff, 6'd0);
    send_command(CMD_BACK, 32'sh80000000, 6'd63);
    send_command(CMD_FRONT, -32'sh1, 6'd0);
    send_command(CMD_BACK, 32'sh0, 6'd0);
    send_command(CMD_BACK, 32'sh1, 6'd0);
    send_command(CMD_BAD, -32'sh1, 6'd63);
    send_command(CMD_DELETE, 32'sh0, 6'd63);  // past the end
    send_command(CMD_DELETE, 32'sh0, 6'd5);   // just past the end
    send_command(CMD_DELETE, 32'sh0, 6'd4);   // last element
    send_command(CMD_DELETE, 32'sh0, 6'd1);   // middle
    send_command(CMD_DELETE, 32'sh0, 6'd0);   // front
    send_command(CMD_DELETE, 32'sh0, 6'd1);
    send_command(CMD_DELETE, 32'sh0, 6'd0);   // only element left
    send_command(CMD_BACK, 32'sh55555555, 6'd42);
    send_command(CMD_FRONT, 32'shaaaaaaaa, 6'd21);
    send_command(CMD_DELETE, 32'sh0, 6'd2);
    send_command(CMD_DELETE, 32'sh0, 6'd1);
    send_command(CMD_DELETE, 32'sh0, 6'd0);

    // Mixed traffic, then a full pause on the command side.
    repeat (5) send_random(60, 30);
    wait_for_dumps();

    // Fill to capacity with roles swapped; halfway up the receiver holds off
    // so the block backs up while commands keep coming. Then inserts on a
    // full list, which must be dropped.
    send_idle_pct = 68;
    recv_idle_pct = 28;
    while (mirror.occupancy() < DEPTH) begin
      if (!held && mirror.occupancy() >= DEPTH / 2) begin
        held = 1'b1;
        holds_asked++;
      end
      send_random(95, 4);
    end
    repeat (3) send_random(100, 0);

    // No idling: drain with mostly deletes.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) send_random(15, 80);

    wait_for_dumps();
    repeat (DRAIN_TICKS) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sid_pkg.sv
rtl/core/sid_if.sv
rtl/core/sid_cell.sv
rtl/core/sequence_insert_delete_dump.sv
tb/testbench.sv
